### rtl/frwl_pkg.sv
// Package with the shared constants and codes of the fair reader/writer lock.
package frwl_pkg;

  // Depth of each wait queue and upper bound on the active reader count.
  localparam int unsigned MAX_THREADS = 16;

  // Widths of the queue index and of the counters that reach MAX_THREADS.
  localparam int unsigned QAW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned QCW = $clog2(MAX_THREADS + 1);

  // Fixed field widths of the request and result channels.
  localparam int unsigned MODE_W = 2;
  localparam int unsigned TID_W  = 4;
  localparam int unsigned OUTC_W = 3;
  localparam int unsigned RCNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOCK_RD   = 2'd0,
    MODE_UNLOCK_RD = 2'd1,
    MODE_LOCK_WR   = 2'd2,
    MODE_UNLOCK_WR = 2'd3
  } mode_e;

  typedef enum logic [OUTC_W-1:0] {
    OUT_GRANTED = 3'd0,
    OUT_QUEUED  = 3'd1,
    OUT_WOKEN   = 3'd2,
    OUT_NONE    = 3'd3,
    OUT_ERROR   = 3'd4
  } outcome_e;

endpackage

### rtl/frwl_req_if.sv
// Request channel: lock or unlock request from one thread.
interface frwl_req_if;
  logic                        valid;
  logic                        ready;
  logic [frwl_pkg::MODE_W-1:0] mode;
  logic [frwl_pkg::TID_W-1:0]  thread_id;

  modport source (output valid, output mode, output thread_id, input ready);
  modport sink (input valid, input mode, input thread_id, output ready);
endinterface

### rtl/frwl_res_if.sv
// Result channel: one outcome of a lock request and the lock state after it.
interface frwl_res_if;
  logic                        valid;
  logic                        ready;
  logic [frwl_pkg::OUTC_W-1:0] outcome;
  logic [frwl_pkg::TID_W-1:0]  woken_thread;
  logic                        last;
  logic [frwl_pkg::RCNT_W-1:0] readers_active;
  logic                        writer_holds;

  modport source (
    output valid, output outcome, output woken_thread, output last,
    output readers_active, output writer_holds, input ready
  );
  modport sink (
    input valid, input outcome, input woken_thread, input last,
    input readers_active, input writer_holds, output ready
  );
endinterface

### rtl/fair_reader_writer_lock.sv
// Fair reader/writer lock arbiter with reader and writer wait queues in memories.
// A request that grants, queues or fails passes through SEND into the output register;
// a request that hands over to a queued writer first passes through POPW (one writer-queue read).
// A writer unlock that wakes N queued readers gives one result per cycle while the consumer does not stall.
// One request at a time: the next is taken only after the last result of the previous one is loaded.
// Reset (rst_ni low, asynchronous): lock free, no readers, both queues empty, no result pending.
module fair_reader_writer_lock (
  input  logic       clk_i,
  input  logic       rst_ni,
  frwl_req_if.sink   req_i,
  frwl_res_if.source res_o
);
  import frwl_pkg::*;

  // Sequencer states. IDLE takes a request; SEND hands a single prepared result to the
  // output register; POPW waits for the writer queue read; WAKE drains the reader queue.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEND = 2'd1;
  localparam logic [1:0] S_POPW = 2'd2;
  localparam logic [1:0] S_WAKE = 2'd3;

  // Wraps a queue index around the queue depth.
  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    logic [QAW:0] s;
    s = {1'b0, p} + 1'b1;
    if (s >= (QAW + 1)'(MAX_THREADS)) begin
      s = '0;
    end
    return s[QAW-1:0];
  endfunction

  // Slot behind the last queued entry, that is head plus count modulo the depth.
  function automatic logic [QAW-1:0] tail_of(input logic [QAW-1:0] h,
                                             input logic [QCW-1:0] c);
    logic [QCW:0] s;
    s = (QCW + 1)'(h) + (QCW + 1)'(c);
    if (s >= (QCW + 1)'(MAX_THREADS)) begin
      s = s - (QCW + 1)'(MAX_THREADS);
    end
    return s[QAW-1:0];
  endfunction

  logic [1:0]       state_q, state_d;
  logic             write_held_q, write_held_d;
  logic [QCW-1:0]   reader_count_q, reader_count_d;
  logic [QAW-1:0]   rq_head_q, rq_head_d;
  logic [QCW-1:0]   rq_cnt_q, rq_cnt_d;
  logic [QAW-1:0]   wq_head_q, wq_head_d;
  logic [QCW-1:0]   wq_cnt_q, wq_cnt_d;

  // Result being prepared for the single-result requests.
  outcome_e         pend_outc_q, pend_outc_d;
  logic [TID_W-1:0] pend_tid_q, pend_tid_d;

  // Output register; it decouples the sequencer from a stalled consumer.
  logic             out_valid_q;
  outcome_e         out_outc_q;
  logic [TID_W-1:0] out_tid_q;
  logic             out_last_q;
  logic [RCNT_W-1:0] out_ra_q;
  logic             out_wh_q;

  logic             out_load;
  outcome_e         out_outc;
  logic [TID_W-1:0] out_tid;
  logic             out_last;
  logic [RCNT_W-1:0] out_ra;
  logic             out_wh;

  // Wait queue memories: one write port and one registered read port each.
  logic [TID_W-1:0] rq_mem [MAX_THREADS];
  logic [TID_W-1:0] wq_mem [MAX_THREADS];
  logic [TID_W-1:0] rq_rdata_q;
  logic [TID_W-1:0] wq_rdata_q;
  logic [QAW-1:0]   rq_raddr;
  logic             rq_we, wq_we;
  logic [QAW-1:0]   rq_waddr, wq_waddr;

  logic             req_fire;
  logic             slot_free;
  logic             rq_full, wq_full;
  mode_e            req_mode;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_mode    = mode_e'(req_i.mode);
  assign slot_free   = !out_valid_q || res_o.ready;
  assign rq_full     = (rq_cnt_q == QCW'(MAX_THREADS));
  assign wq_full     = (wq_cnt_q == QCW'(MAX_THREADS));
  assign rq_waddr    = tail_of(rq_head_q, rq_cnt_q);
  assign wq_waddr    = tail_of(wq_head_q, wq_cnt_q);

  // The reader queue is read ahead: while WAKE pops an entry, the read already targets the
  // next head, so the following reader's id is ready in the next cycle.
  assign rq_raddr = (state_q == S_WAKE && slot_free) ? ptr_inc(rq_head_q) : rq_head_q;

  always_comb begin
    state_d        = state_q;
    write_held_d   = write_held_q;
    reader_count_d = reader_count_q;
    rq_head_d      = rq_head_q;
    rq_cnt_d       = rq_cnt_q;
    wq_head_d      = wq_head_q;
    wq_cnt_d       = wq_cnt_q;
    pend_outc_d    = pend_outc_q;
    pend_tid_d     = pend_tid_q;
    rq_we          = 1'b0;
    wq_we          = 1'b0;
    out_load       = 1'b0;
    out_outc       = pend_outc_q;
    out_tid        = pend_tid_q;
    out_last       = 1'b1;
    out_ra         = RCNT_W'(reader_count_q);
    out_wh         = write_held_q;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          // All lock state changes of a single-result request are made here, so that the
          // result reports the state after it.
          pend_tid_d = req_i.thread_id;
          state_d    = S_SEND;
          case (req_mode)
            MODE_LOCK_RD: begin
              if (wq_cnt_q != '0 || write_held_q) begin
                // Writers have priority: a reader waits behind any queued writer.
                if (rq_full) begin
                  pend_outc_d = OUT_ERROR;
                end else begin
                  rq_we       = 1'b1;
                  rq_cnt_d    = rq_cnt_q + 1'b1;
                  pend_outc_d = OUT_QUEUED;
                end
              end else if (reader_count_q >= QCW'(MAX_THREADS)) begin
                pend_outc_d = OUT_ERROR;
              end else begin
                reader_count_d = reader_count_q + 1'b1;
                pend_outc_d    = OUT_GRANTED;
              end
            end
            MODE_UNLOCK_RD: begin
              if (write_held_q || reader_count_q == '0) begin
                pend_outc_d = OUT_ERROR;
              end else begin
                reader_count_d = reader_count_q - 1'b1;
                if (reader_count_q == QCW'(1) && wq_cnt_q != '0) begin
                  // The last reader leaves: the oldest waiting writer takes the lock. Its id
                  // comes out of the writer queue read issued in this cycle.
                  write_held_d = 1'b1;
                  wq_head_d    = ptr_inc(wq_head_q);
                  wq_cnt_d     = wq_cnt_q - 1'b1;
                  pend_outc_d  = OUT_WOKEN;
                  state_d      = S_POPW;
                end else begin
                  pend_outc_d = OUT_NONE;
                end
              end
            end
            MODE_LOCK_WR: begin
              if (reader_count_q != '0 || write_held_q) begin
                if (wq_full) begin
                  pend_outc_d = OUT_ERROR;
                end else begin
                  wq_we       = 1'b1;
                  wq_cnt_d    = wq_cnt_q + 1'b1;
                  pend_outc_d = OUT_QUEUED;
                end
              end else begin
                write_held_d = 1'b1;
                pend_outc_d  = OUT_GRANTED;
              end
            end
            MODE_UNLOCK_WR: begin
              if (!write_held_q || reader_count_q != '0) begin
                pend_outc_d = OUT_ERROR;
              end else if (rq_cnt_q != '0) begin
                // Every waiting reader is released, one result each, in queue order.
                write_held_d = 1'b0;
                state_d      = S_WAKE;
              end else if (wq_cnt_q != '0) begin
                // The lock passes straight to the next writer and stays write-held.
                wq_head_d   = ptr_inc(wq_head_q);
                wq_cnt_d    = wq_cnt_q - 1'b1;
                pend_outc_d = OUT_WOKEN;
                state_d     = S_POPW;
              end else begin
                write_held_d = 1'b0;
                pend_outc_d  = OUT_NONE;
              end
            end
            default: begin
              pend_outc_d = OUT_ERROR;
            end
          endcase
        end
      end
      S_POPW: begin
        pend_tid_d = wq_rdata_q;
        state_d    = S_SEND;
      end
      S_SEND: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_WAKE: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_outc       = OUT_WOKEN;
          out_tid        = rq_rdata_q;
          out_last       = (rq_cnt_q == QCW'(1));
          out_ra         = RCNT_W'(reader_count_q + 1'b1);
          out_wh         = 1'b0;
          reader_count_d = reader_count_q + 1'b1;
          rq_head_d      = ptr_inc(rq_head_q);
          rq_cnt_d       = rq_cnt_q - 1'b1;
          if (rq_cnt_q == QCW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      write_held_q   <= 1'b0;
      reader_count_q <= '0;
      rq_head_q      <= '0;
      rq_cnt_q       <= '0;
      wq_head_q      <= '0;
      wq_cnt_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      write_held_q   <= write_held_d;
      reader_count_q <= reader_count_d;
      rq_head_q      <= rq_head_d;
      rq_cnt_q       <= rq_cnt_d;
      wq_head_q      <= wq_head_d;
      wq_cnt_q       <= wq_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_outc_q <= pend_outc_d;
    pend_tid_q  <= pend_tid_d;
    if (out_load) begin
      out_outc_q <= out_outc;
      out_tid_q  <= out_tid;
      out_last_q <= out_last;
      out_ra_q   <= out_ra;
      out_wh_q   <= out_wh;
    end
  end

  // Queue memories. A request never pushes and pops the same queue. A push into an empty queue
  // writes the entry that its read port reads in that cycle; that stale read data is never used.
  always_ff @(posedge clk_i) begin
    if (rq_we) begin
      rq_mem[rq_waddr] <= req_i.thread_id;
    end
    rq_rdata_q <= rq_mem[rq_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wq_we) begin
      wq_mem[wq_waddr] <= req_i.thread_id;
    end
    wq_rdata_q <= wq_mem[wq_head_q];
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.outcome        = out_outc_q;
  assign res_o.woken_thread   = out_tid_q;
  assign res_o.last           = out_last_q;
  assign res_o.readers_active = out_ra_q;
  assign res_o.writer_holds   = out_wh_q;

  // A writer and active readers never hold the lock together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(write_held_q && reader_count_q != '0))
    else $error("lock held by a writer and by readers at once");

  // The reader wake sequence only runs while readers are queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAKE) |-> (rq_cnt_q != '0))
    else $error("reader wake with an empty reader queue");

  // While the sequencer is idle, queued readers always wait on a writer, held or queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && rq_cnt_q != '0) |-> (write_held_q || wq_cnt_q != '0))
    else $error("readers left waiting on a free lock");

  // Queue fill counts stay within the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rq_cnt_q <= QCW'(MAX_THREADS)) && (wq_cnt_q <= QCW'(MAX_THREADS)))
    else $error("wait queue count beyond its depth");

  // A wake result with last set ends the sequence and returns to taking requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAKE && out_load && out_last) |=> (state_q == S_IDLE))
    else $error("reader wake did not end after its last result");

endmodule
